/* sv/knn3_pkg.sv */
// package with shared types and constants of the 3-nn condition classifier
`timescale 1ns / 1ps
`default_nettype none
package knn3_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = 9;
  localparam int DIST_W      = 63;
  localparam int SAMPLE_W    = 61;
  localparam int DRAIN_CYCLES = 10;
  localparam int DRAIN_W     = 4;

  localparam logic [CNT_W-1:0]  RESET_SAMPLE_COUNT = 9'd200;
  localparam logic [31:0] RESET_WEIGHT_AFR  = 32'd24101900;
  localparam logic [31:0] RESET_WEIGHT_RPM  = 32'd3742;
  localparam logic [31:0] RESET_WEIGHT_TEMP = 32'd63741;
  localparam logic [31:0] RESET_WEIGHT_TPS  = 32'd42348;
  localparam logic [31:0] RESET_WEIGHT_MAP  = 32'd33036;

  // rule thresholds in tenths
  localparam logic [9:0]         TPS_IDLE_LIMIT = 10'd10;
  localparam logic signed [12:0] TEMP_COLD_LIMIT = 13'sd650;
  localparam logic signed [12:0] TEMP_HOT_LIMIT  = 13'sd750;
  localparam logic [9:0]         AFR_RICH_LOW   = 10'd110;
  localparam logic [9:0]         AFR_RICH_HIGH  = 10'd120;

  typedef enum logic [2:0] {
    REG_SAMPLE_COUNT = 3'd0,
    REG_WEIGHT_AFR   = 3'd1,
    REG_WEIGHT_RPM   = 3'd2,
    REG_WEIGHT_TEMP  = 3'd3,
    REG_WEIGHT_TPS   = 3'd4,
    REG_WEIGHT_MAP   = 3'd5
  } reg_index_t;

  typedef enum logic [1:0] {
    COND_NORMAL      = 2'd0,
    COND_STARTUP     = 2'd1,
    COND_MAINTENANCE = 2'd2,
    COND_CRITICAL    = 2'd3
  } condition_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // candidate neighbour moving along the cell chain
  typedef struct packed {
    logic              valid;
    logic [DIST_W-1:0] distance;
    logic [ADDR_W-1:0] idx;
    logic [1:0]        label;
  } cand_t;

  typedef struct packed {
    logic [31:0] afr;
    logic [31:0] rpm;
    logic [31:0] temp;
    logic [31:0] tps;
    logic [31:0] map;
  } weights_t;

  typedef struct packed {
    logic [9:0]         afr;
    logic [13:0]        rpm;
    logic signed [12:0] temp;
    logic [9:0]         tps;
    logic [11:0]        map;
  } features_t;

endpackage
`default_nettype wire

/* sv/knn3_ram.sv */
// generic single-write single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module knn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

/* sv/knn3_dist.sv */
// pipelined weighted squared distance between the query and one table entry
`timescale 1ns / 1ps
`default_nettype none
module knn3_dist (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           rd_en,
  input  wire logic [knn3_pkg::ADDR_W-1:0]    rd_addr,
  input  wire logic [knn3_pkg::SAMPLE_W-1:0]  rdata,
  input  wire knn3_pkg::features_t            query,
  input  wire knn3_pkg::weights_t             weights,
  output knn3_pkg::cand_t                     cand
);

  localparam int DW = knn3_pkg::DIST_W;
  localparam int AW = knn3_pkg::ADDR_W;

  knn3_pkg::features_t smp;
  logic [1:0]          smp_label;

  // stage valids and tags
  logic          v1_r, v2_r, v3_r, v4_r, v5_r;
  logic [AW-1:0] idx1_r, idx2_r, idx3_r, idx4_r, idx5_r;
  logic [1:0]    lab2_r, lab3_r, lab4_r, lab5_r;

  logic [9:0]  d_afr_nxt, d_tps_nxt;
  logic [13:0] d_rpm_nxt;
  logic [12:0] d_temp_nxt;
  logic [11:0] d_map_nxt;
  logic signed [13:0] temp_diff;

  logic [9:0]  d_afr_r, d_tps_r;
  logic [13:0] d_rpm_r;
  logic [12:0] d_temp_r;
  logic [11:0] d_map_r;

  logic [19:0] sq_afr_r, sq_tps_r;
  logic [27:0] sq_rpm_r;
  logic [25:0] sq_temp_r;
  logic [23:0] sq_map_r;

  logic [51:0] p_afr_r, p_tps_r;
  logic [59:0] p_rpm_r;
  logic [57:0] p_temp_r;
  logic [55:0] p_map_r;

  logic [DW-1:0] sum_a_r, sum_b_r;

  assign {smp.afr, smp.rpm, smp.temp, smp.tps, smp.map, smp_label} = rdata;

  always_comb begin
    d_afr_nxt  = (query.afr > smp.afr) ? query.afr - smp.afr : smp.afr - query.afr;
    d_rpm_nxt  = (query.rpm > smp.rpm) ? query.rpm - smp.rpm : smp.rpm - query.rpm;
    temp_diff  = 14'(query.temp) - 14'(smp.temp);
    d_temp_nxt = temp_diff[13] ? 13'(-temp_diff) : temp_diff[12:0];
    d_tps_nxt  = (query.tps > smp.tps) ? query.tps - smp.tps : smp.tps - query.tps;
    d_map_nxt  = (query.map > smp.map) ? query.map - smp.map : smp.map - query.map;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      cand.valid <= 1'b0;
    end else begin
      v1_r <= rd_en;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      cand.valid <= v5_r;
    end
    cand.idx      <= idx5_r;
    cand.label    <= lab5_r;
    cand.distance <= sum_a_r + sum_b_r;
  end

  always_ff @(posedge clk) begin
    idx1_r <= rd_addr;
    // absolute differences
    idx2_r   <= idx1_r;
    lab2_r   <= smp_label;
    d_afr_r  <= d_afr_nxt;
    d_rpm_r  <= d_rpm_nxt;
    d_temp_r <= d_temp_nxt;
    d_tps_r  <= d_tps_nxt;
    d_map_r  <= d_map_nxt;
    // squares
    idx3_r    <= idx2_r;
    lab3_r    <= lab2_r;
    sq_afr_r  <= 20'(d_afr_r) * 20'(d_afr_r);
    sq_rpm_r  <= 28'(d_rpm_r) * 28'(d_rpm_r);
    sq_temp_r <= 26'(d_temp_r) * 26'(d_temp_r);
    sq_tps_r  <= 20'(d_tps_r) * 20'(d_tps_r);
    sq_map_r  <= 24'(d_map_r) * 24'(d_map_r);
    // weighting
    idx4_r   <= idx3_r;
    lab4_r   <= lab3_r;
    p_afr_r  <= 52'(sq_afr_r) * 52'(weights.afr);
    p_rpm_r  <= 60'(sq_rpm_r) * 60'(weights.rpm);
    p_temp_r <= 58'(sq_temp_r) * 58'(weights.temp);
    p_tps_r  <= 52'(sq_tps_r) * 52'(weights.tps);
    p_map_r  <= 56'(sq_map_r) * 56'(weights.map);
    // two partial sums, then the total
    idx5_r  <= idx4_r;
    lab5_r  <= lab4_r;
    sum_a_r <= DW'(p_afr_r) + DW'(p_rpm_r) + DW'(p_temp_r);
    sum_b_r <= DW'(p_tps_r) + DW'(p_map_r);
  end

endmodule
`default_nettype wire

/* sv/knn3_cell.sv */
// one cell of the sorted nearest-neighbour chain
`timescale 1ns / 1ps
`default_nettype none
module knn3_cell (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            clear,
  input  wire knn3_pkg::cand_t cand_in,
  output knn3_pkg::cand_t      held,
  output knn3_pkg::cand_t      pass_out
);

  knn3_pkg::cand_t held_r, held_nxt, pass_r, pass_nxt;
  logic            closer;

  // order by distance, then by table index
  assign closer = {cand_in.distance, cand_in.idx} < {held_r.distance, held_r.idx};

  always_comb begin
    held_nxt = held_r;
    pass_nxt = cand_in;
    if (cand_in.valid) begin
      if (!held_r.valid) begin
        held_nxt       = cand_in;
        pass_nxt.valid = 1'b0;
      end else if (closer) begin
        held_nxt = cand_in;
        pass_nxt = held_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      held_r.valid <= 1'b0;
      pass_r.valid <= 1'b0;
    end else begin
      held_r.valid <= held_nxt.valid;
      pass_r.valid <= pass_nxt.valid;
    end
    held_r.distance <= held_nxt.distance;
    held_r.idx      <= held_nxt.idx;
    held_r.label    <= held_nxt.label;
    pass_r.distance <= pass_nxt.distance;
    pass_r.idx      <= pass_nxt.idx;
    pass_r.label    <= pass_nxt.label;
  end

  assign held     = held_r;
  assign pass_out = pass_r;

endmodule
`default_nettype wire

/* sv/knn3_engine_condition_classifier_core.sv */
// top level of the three-nearest-neighbour engine condition classifier
// usage:
// - input channel (in_valid / in_stall) carries load and query transactions
// - a load (in_kind 0) writes the features and label into table entry in_slot
//   and produces no result
// - a query (in_kind 1) first checks the fixed idle and rich-mixture rules;
//   a rule hit gives a registered result in the cycle after acceptance
// - otherwise the first sample_count entries (at most 256) are streamed from
//   the sample ram, one per cycle, through the distance pipeline into a row
//   of three sorting cells; after the scan and the pipeline drain the vote
//   is registered as the result, and the next transaction is taken after
//   it is loaded; the single ram read port feeds one entry per cycle
// - one query is in work at a time; in_stall is high while a scan runs
// - the result sits in an output register; in_stall also rises while a
//   finished result waits and the receiver holds out_stall
// - user keeps config writes (cfg_we,cfg_index,cfg_wdata) to idle; unchecked
// - reset restores the register defaults; table entries stay undefined
//   until loaded, so only loaded entries may be searched
`timescale 1ns / 1ps
`default_nettype none
module knn3_engine_condition_classifier_core (
  input  wire logic              clk,
  input  wire logic              rst_n,
  // input channel
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_kind,
  input  wire logic [7:0]        in_slot,
  input  wire logic [9:0]        in_afr_tenths,
  input  wire logic [13:0]       in_engine_rpm,
  input  wire logic signed [12:0] in_temp_tenths,
  input  wire logic [9:0]        in_throttle_tenths,
  input  wire logic [11:0]       in_pressure_tenths,
  input  wire logic [1:0]        in_label,
  // result channel
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             out_condition,
  output logic                   out_by_rule,
  // config port
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  localparam int AW = knn3_pkg::ADDR_W;
  localparam int CW = knn3_pkg::CNT_W;

  // config registers
  logic [CW-1:0]       sample_count_r;
  knn3_pkg::weights_t  weights_r;

  // control
  knn3_pkg::state_t    state_r, state_nxt;
  logic [CW-1:0]       scan_cnt_r, scan_cnt_nxt;
  logic [CW-1:0]       n_r, n_nxt;
  logic [knn3_pkg::DRAIN_W-1:0] drain_r, drain_nxt;
  knn3_pkg::features_t query_r, query_in;

  logic          accept, is_query, rule_hit, load_query, clear_cells;
  logic [1:0]    rule_cond;
  logic          out_free, out_valid_r, out_load;
  logic [1:0]    out_cond_r, out_cond_nxt;
  logic          out_rule_r, out_rule_nxt;
  logic [CW-1:0] n_eff;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic [knn3_pkg::SAMPLE_W-1:0] rdata;

  knn3_pkg::cand_t cand0, pass0, pass1, pass2, held0, held1, held2;
  logic [1:0]      vote_cond;

  // config write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_count_r <= knn3_pkg::RESET_SAMPLE_COUNT;
      weights_r.afr  <= knn3_pkg::RESET_WEIGHT_AFR;
      weights_r.rpm  <= knn3_pkg::RESET_WEIGHT_RPM;
      weights_r.temp <= knn3_pkg::RESET_WEIGHT_TEMP;
      weights_r.tps  <= knn3_pkg::RESET_WEIGHT_TPS;
      weights_r.map  <= knn3_pkg::RESET_WEIGHT_MAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        knn3_pkg::REG_SAMPLE_COUNT: sample_count_r <= cfg_wdata[CW-1:0];
        knn3_pkg::REG_WEIGHT_AFR:   weights_r.afr  <= cfg_wdata;
        knn3_pkg::REG_WEIGHT_RPM:   weights_r.rpm  <= cfg_wdata;
        knn3_pkg::REG_WEIGHT_TEMP:  weights_r.temp <= cfg_wdata;
        knn3_pkg::REG_WEIGHT_TPS:   weights_r.tps  <= cfg_wdata;
        knn3_pkg::REG_WEIGHT_MAP:   weights_r.map  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign query_in.afr  = in_afr_tenths;
  assign query_in.rpm  = in_engine_rpm;
  assign query_in.temp = in_temp_tenths;
  assign query_in.tps  = in_throttle_tenths;
  assign query_in.map  = in_pressure_tenths;

  // handshake
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != knn3_pkg::ST_IDLE) || !out_free;
  assign accept   = in_valid && !in_stall;
  assign is_query = in_kind;

  // fixed rules, checked in order
  always_comb begin
    rule_hit  = 1'b1;
    rule_cond = knn3_pkg::COND_NORMAL;
    if (in_throttle_tenths < knn3_pkg::TPS_IDLE_LIMIT &&
        in_temp_tenths < knn3_pkg::TEMP_COLD_LIMIT) begin
      rule_cond = knn3_pkg::COND_STARTUP;
    end else if (in_throttle_tenths < knn3_pkg::TPS_IDLE_LIMIT &&
                 in_temp_tenths >= knn3_pkg::TEMP_HOT_LIMIT) begin
      rule_cond = knn3_pkg::COND_MAINTENANCE;
    end else if (in_afr_tenths >= knn3_pkg::AFR_RICH_LOW &&
                 in_afr_tenths <= knn3_pkg::AFR_RICH_HIGH) begin
      rule_cond = knn3_pkg::COND_CRITICAL;
    end else begin
      rule_hit = 1'b0;
    end
  end

  // count above table depth clamps to the depth
  assign n_eff = (sample_count_r > CW'(knn3_pkg::TABLE_DEPTH)) ?
                 CW'(knn3_pkg::TABLE_DEPTH) : sample_count_r;

  // vote over the valid cells; nearest label breaks a split
  always_comb begin
    vote_cond = held0.valid ? held0.label : knn3_pkg::COND_NORMAL;
    if (held1.valid && held2.valid && held1.label == held2.label) begin
      vote_cond = held1.label;
    end
    if (held0.valid && held2.valid && held0.label == held2.label) begin
      vote_cond = held0.label;
    end
    if (held0.valid && held1.valid && held0.label == held1.label) begin
      vote_cond = held0.label;
    end
  end

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    scan_cnt_nxt = scan_cnt_r;
    n_nxt        = n_r;
    drain_nxt    = drain_r;
    load_query   = 1'b0;
    clear_cells  = 1'b0;
    rd_en        = 1'b0;
    out_load     = 1'b0;
    out_cond_nxt = out_cond_r;
    out_rule_nxt = out_rule_r;
    unique case (state_r)
      knn3_pkg::ST_IDLE: begin
        if (accept && is_query) begin
          if (rule_hit) begin
            out_load     = 1'b1;
            out_cond_nxt = rule_cond;
            out_rule_nxt = 1'b1;
          end else begin
            load_query   = 1'b1;
            clear_cells  = 1'b1;
            n_nxt        = n_eff;
            scan_cnt_nxt = '0;
            drain_nxt    = '0;
            // empty search goes straight to the result
            state_nxt    = (n_eff == '0) ? knn3_pkg::ST_DONE : knn3_pkg::ST_SCAN;
          end
        end
      end
      knn3_pkg::ST_SCAN: begin
        rd_en        = 1'b1;
        scan_cnt_nxt = scan_cnt_r + 1'b1;
        if (scan_cnt_r == n_r - 1'b1) begin
          state_nxt = knn3_pkg::ST_DRAIN;
        end
      end
      knn3_pkg::ST_DRAIN: begin
        drain_nxt = drain_r + 1'b1;
        if (drain_r == knn3_pkg::DRAIN_W'(knn3_pkg::DRAIN_CYCLES - 1)) begin
          state_nxt = knn3_pkg::ST_DONE;
        end
      end
      knn3_pkg::ST_DONE: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_cond_nxt = vote_cond;
          out_rule_nxt = 1'b0;
          state_nxt    = knn3_pkg::ST_IDLE;
        end
      end
      default: state_nxt = knn3_pkg::ST_IDLE;
    endcase
  end

  assign rd_addr = scan_cnt_r[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= knn3_pkg::ST_IDLE;
      scan_cnt_r  <= '0;
      n_r         <= '0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_cnt_r <= scan_cnt_nxt;
      n_r        <= n_nxt;
      drain_r    <= drain_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_query) begin
      query_r <= query_in;
    end
    out_cond_r <= out_cond_nxt;
    out_rule_r <= out_rule_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_condition = out_cond_r;
  assign out_by_rule   = out_rule_r;

  // sample table: afr, rpm, temp, tps, map, label
  knn3_ram #(
    .WIDTH(knn3_pkg::SAMPLE_W),
    .DEPTH(knn3_pkg::TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (accept && !is_query),
    .waddr(in_slot[AW-1:0]),
    .wdata({in_afr_tenths, in_engine_rpm, in_temp_tenths, in_throttle_tenths,
            in_pressure_tenths, in_label}),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  knn3_dist u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rdata  (rdata),
    .query  (query_r),
    .weights(weights_r),
    .cand   (cand0)
  );

  // three cells: nearest first, displaced entries ripple down
  knn3_cell u_cell0 (
    .clk(clk), .rst_n(rst_n), .clear(clear_cells),
    .cand_in(cand0), .held(held0), .pass_out(pass0)
  );
  knn3_cell u_cell1 (
    .clk(clk), .rst_n(rst_n), .clear(clear_cells),
    .cand_in(pass0), .held(held1), .pass_out(pass1)
  );
  knn3_cell u_cell2 (
    .clk(clk), .rst_n(rst_n), .clear(clear_cells),
    .cand_in(pass1), .held(held2), .pass_out(pass2)
  );

  // assertions
  a_rise_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == knn3_pkg::ST_IDLE ||
                            $past(state_r) == knn3_pkg::ST_DONE))
    else $error("result appeared outside idle or done");

  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == knn3_pkg::ST_SCAN |-> scan_cnt_r < n_r)
    else $error("scan address beyond sample count");

  a_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == knn3_pkg::ST_DONE |-> !cand0.valid && !pass0.valid && !pass1.valid)
    else $error("vote taken before the chain settled");

  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == knn3_pkg::ST_DONE && n_r >= CW'(3)) |->
      (held0.valid && held1.valid && held2.valid && !pass2.valid || pass2.valid))
    else $error("fewer than three neighbours after a full scan");

endmodule
`default_nettype wire

/* tb/sv/knn3_engine_condition_classifier_core_tb.sv */
// testbench of the 3-nn engine condition classifier: random and directed loads and queries
`timescale 1ns / 1ps
`default_nettype none

class condition_scoreboard;
  // predictor state
  logic [9:0]         tbl_afr[256];
  logic [13:0]        tbl_rpm[256];
  logic signed [12:0] tbl_temp[256];
  logic [9:0]         tbl_tps[256];
  logic [11:0]        tbl_map[256];
  logic [1:0]         tbl_label[256];
  bit [8:0]  sample_count;
  bit [31:0] w_afr, w_rpm, w_temp, w_tps, w_map;
  // expected results, condition in [2:1] and by_rule in [0]
  bit [2:0]  pending_conditions[$];
  int        fail_count;

  function new();
    sample_count = 9'd200;
    w_afr = 32'd24101900; w_rpm = 32'd3742; w_temp = 32'd63741;
    w_tps = 32'd42348; w_map = 32'd33036;
    fail_count = 0;
  endfunction

  function void set_reg(int idx, bit [31:0] v);
    case (idx)
      0: sample_count = v[8:0];
      1: w_afr = v;
      2: w_rpm = v;
      3: w_temp = v;
      4: w_tps = v;
      5: w_map = v;
      default: ;
    endcase
  endfunction

  function longint unsigned wsq(int a, int b, bit [31:0] w);
    longint unsigned d;
    d = (a > b) ? longint'(a - b) : longint'(b - a);
    return d * d * longint'(w);
  endfunction

  function void note_input(bit kind, bit [7:0] slot, bit [9:0] afr, bit [13:0] rpm,
                           logic signed [12:0] temp, bit [9:0] tps, bit [11:0] map,
                           bit [1:0] label);
    longint unsigned best_d[3];
    bit [1:0] best_l[3];
    int votes[4];
    int found, n, k;
    longint unsigned d;
    bit [1:0] cond;
    if (!kind) begin
      tbl_afr[slot] = afr; tbl_rpm[slot] = rpm; tbl_temp[slot] = temp;
      tbl_tps[slot] = tps; tbl_map[slot] = map; tbl_label[slot] = label;
      return;
    end
    if (tps < 10 && temp < 650) begin
      pending_conditions.push_back({2'd1, 1'b1}); return;
    end
    if (tps < 10 && temp >= 750) begin
      pending_conditions.push_back({2'd2, 1'b1}); return;
    end
    if (afr >= 110 && afr <= 120) begin
      pending_conditions.push_back({2'd3, 1'b1}); return;
    end
    n = (sample_count > 256) ? 256 : sample_count;
    found = 0;
    for (int i = 0; i < n; i++) begin
      d = wsq(afr, tbl_afr[i], w_afr) + wsq(rpm, tbl_rpm[i], w_rpm)
        + wsq(int'(temp), int'(tbl_temp[i]), w_temp)
        + wsq(tps, tbl_tps[i], w_tps) + wsq(map, tbl_map[i], w_map);
      // insertion keeps lower index on equal distance
      k = found;
      while (k > 0 && d < best_d[k-1]) begin
        if (k < 3) begin
          best_d[k] = best_d[k-1]; best_l[k] = best_l[k-1];
        end
        k--;
      end
      if (k < 3) begin
        best_d[k] = d; best_l[k] = tbl_label[i];
        if (found < 3) found++;
      end
    end
    cond = 2'd0;
    votes = '{0, 0, 0, 0};
    if (found > 0) begin
      cond = best_l[0];
      for (int j = 0; j < found; j++) votes[best_l[j]]++;
      for (int j = 0; j < 4; j++) if (votes[j] >= 2) cond = j[1:0];
    end
    pending_conditions.push_back({cond, 1'b0});
  endfunction

  function void check_result(bit [1:0] cond, bit by_rule);
    bit [2:0] e;
    if (pending_conditions.size() == 0) begin
      $error("result with no expectation: condition %0d by_rule %0d", cond, by_rule);
      fail_count++;
      return;
    end
    e = pending_conditions.pop_front();
    if (cond !== e[2:1]) begin
      $error("condition: expected %0d actual %0d", e[2:1], cond); fail_count++;
    end
    if (by_rule !== e[0]) begin
      $error("by_rule: expected %0d actual %0d", e[0], by_rule); fail_count++;
    end
  endfunction
endclass

module knn3_engine_condition_classifier_core_tb;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_kind = 1'b0;
  logic [7:0] in_slot = '0;
  logic [9:0] in_afr_tenths = '0;
  logic [13:0] in_engine_rpm = '0;
  logic signed [12:0] in_temp_tenths = '0;
  logic [9:0] in_throttle_tenths = '0;
  logic [11:0] in_pressure_tenths = '0;
  logic [1:0] in_label = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_condition;
  logic out_by_rule;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_wdata = '0;

  condition_scoreboard sb = new();
  bit calm;            // long stretch with no idling on either side

  always #2 clk = ~clk;

  knn3_engine_condition_classifier_core u_top (.*);

  // result side: random stall, check each result as it is taken
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_condition, out_by_rule);
      out_stall <= calm ? 1'b0 : ($urandom_range(99) < 23);
    end
  end

  // valid stays high after acceptance so back to back transactions need no gap
  task automatic send_item(bit kind, bit [7:0] slot, bit [9:0] afr, bit [13:0] rpm,
                           logic signed [12:0] temp, bit [9:0] tps, bit [11:0] map,
                           bit [1:0] label);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1; in_kind <= kind; in_slot <= slot; in_afr_tenths <= afr;
    in_engine_rpm <= rpm; in_temp_tenths <= temp; in_throttle_tenths <= tps;
    in_pressure_tenths <= map; in_label <= label;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(kind, slot, afr, rpm, temp, tps, map, label);
  endtask

  task automatic rand_load(bit [7:0] slot);
    send_item(1'b0, slot, 10'($urandom), 14'($urandom),
              13'(int'($urandom_range(3000)) - 500), 10'($urandom), 12'($urandom),
              2'($urandom));
  endtask

  // mostly vote queries, some rule hits, occasional out-of-range bit patterns
  task automatic rand_query();
    logic signed [12:0] t;
    bit [9:0] tps, afr;
    t = 13'(int'($urandom_range(3000)) - 500);
    if ($urandom_range(9) == 0) t = 13'($urandom);
    tps = ($urandom_range(4) == 0) ? 10'($urandom_range(9)) : 10'($urandom);
    afr = ($urandom_range(7) == 0) ? 10'($urandom_range(120, 110)) : 10'($urandom);
    send_item(1'b1, 8'($urandom), afr, 14'($urandom), t, tps, 12'($urandom),
              2'($urandom));
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending_conditions.size() != 0) @(posedge clk);
    repeat (knn3_pkg::DRAIN_CYCLES + 20) @(posedge clk);
  endtask

  task automatic write_reg(knn3_pkg::reg_index_t idx, bit [31:0] v);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_wdata <= v;
    @(posedge clk);
    sb.set_reg(int'(idx), v);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    calm = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // fill every entry so any count is safe
    for (int i = 0; i < 256; i++) rand_load(8'(i));
    // directed: rule edges and field extremes
    send_item(1'b1, 8'hff, 10'd0, 14'd0, 13'sd649, 10'd9, 12'd0, 2'd3);
    send_item(1'b1, 8'd0, 10'd0, 14'd0, 13'sd650, 10'd9, 12'd0, 2'd0);
    send_item(1'b1, 8'd0, 10'd0, 14'd0, 13'sd749, 10'd0, 12'd0, 2'd0);
    send_item(1'b1, 8'd0, 10'd1023, 14'd16383, 13'sd750, 10'd0, 12'd4095, 2'd0);
    send_item(1'b1, 8'd0, 10'd1023, 14'd16383, -13'sd500, 10'd0, 12'd4095, 2'd0);
    send_item(1'b1, 8'd0, 10'd110, 14'd0, 13'sd2500, 10'd10, 12'd0, 2'd0);
    send_item(1'b1, 8'd0, 10'd120, 14'd0, 13'sd700, 10'd1023, 12'd0, 2'd0);
    send_item(1'b1, 8'd0, 10'd109, 14'd0, 13'sd700, 10'd10, 12'd0, 2'd0);
    send_item(1'b1, 8'd0, 10'd121, 14'd16383, -13'sd4096, 10'd1023, 12'd4095, 2'd0);
    send_item(1'b1, 8'd0, 10'd1023, 14'd16383, 13'sd4095, 10'd1023, 12'd4095, 2'd0);
    // exact duplicate samples give distance ties
    send_item(1'b0, 8'd0, 10'd500, 14'd3000, 13'sd900, 10'd300, 12'd1000, 2'd2);
    send_item(1'b0, 8'd1, 10'd500, 14'd3000, 13'sd900, 10'd300, 12'd1000, 2'd1);
    send_item(1'b0, 8'd2, 10'd500, 14'd3000, 13'sd900, 10'd300, 12'd1000, 2'd3);
    send_item(1'b1, 8'd0, 10'd500, 14'd3000, 13'sd900, 10'd300, 12'd1000, 2'd0);
    wait_idle();
    // small count settings: 3, 2, 1, 0 and above depth
    for (int c = 0; c < 5; c++) begin
      write_reg(knn3_pkg::REG_SAMPLE_COUNT, (c == 4) ? 32'h1ff : 32'(3 - c));
      send_item(1'b1, 8'd0, 10'd500, 14'd3000, 13'sd900, 10'd300, 12'd1000, 2'd0);
      send_item(1'b1, 8'd7, 10'd0, 14'd9, 13'sd1000, 10'd900, 12'd7, 2'd1);
      wait_idle();
    end
    // random phases with varied settings
    for (int ph = 0; ph < 8; ph++) begin
      calm = (ph == 3);
      case (ph)
        0: write_reg(knn3_pkg::REG_SAMPLE_COUNT, 32'd256);
        1: write_reg(knn3_pkg::REG_SAMPLE_COUNT, 32'd3);
        default: write_reg(knn3_pkg::REG_SAMPLE_COUNT, 32'($urandom_range(40, 3)));
      endcase
      write_reg(knn3_pkg::REG_WEIGHT_AFR,
                ph == 1 ? 32'hffffffff : (ph == 2 ? 32'd0 : $urandom));
      write_reg(knn3_pkg::REG_WEIGHT_RPM,
                ph == 1 ? 32'hffffffff : (ph == 2 ? 32'd0 : $urandom));
      write_reg(knn3_pkg::REG_WEIGHT_TEMP,
                ph == 1 ? 32'hffffffff : (ph == 2 ? 32'd0 : $urandom));
      write_reg(knn3_pkg::REG_WEIGHT_TPS,
                ph == 1 ? 32'hffffffff : (ph == 2 ? 32'd0 : $urandom));
      write_reg(knn3_pkg::REG_WEIGHT_MAP,
                ph == 1 ? 32'hffffffff : (ph == 2 ? 32'd0 : $urandom));
      for (int i = 0; i < 55; i++) begin
        if ($urandom_range(3) == 0) rand_load(8'($urandom));
        else rand_query();
      end
      wait_idle();
    end
    calm = 1'b0;
    wait_idle();
    if (sb.fail_count == 0 && sb.pending_conditions.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire

/* sim.f */
sv/knn3_pkg.sv
sv/knn3_ram.sv
sv/knn3_dist.sv
sv/knn3_cell.sv
sv/knn3_engine_condition_classifier_core.sv
tb/sv/knn3_engine_condition_classifier_core_tb.sv
